@@ sv/phm_pkg.sv @@
// Package: widths, reset values and register codes for the producer health monitor.
`timescale 1ns / 1ps

package phm_pkg;

    localparam int TIME_W   = 64;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 32;
    localparam int PERIOD_W = 30;
    localparam int ADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam int IN_W  = 5 * TIME_W;
    localparam int OUT_W = 104;

    localparam logic [CFG_W-1:0]    STALE_THRESHOLD_RST = 32'd100;
    localparam logic [CFG_W-1:0]    STALE_INTERVAL_RST  = 32'd30000;
    localparam logic [CFG_W-1:0]    PACING_INTERVAL_RST = 32'd5000;
    localparam logic [PERIOD_W-1:0] BLOCK_PERIOD_RST    = 30'd2666666;

    localparam logic [REG_IDX_W-1:0] REG_STALE_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STALE_INTERVAL  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PACING_INTERVAL = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_PERIOD    = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0] read_index;
        logic [TIME_W-1:0] write_index;
        logic [TIME_W-1:0] block_pts_ns;
        logic [TIME_W-1:0] heartbeat_ms;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic [CNT_W-1:0] pacing_total;
        logic [CNT_W-1:0] stale_total;
        logic [CNT_W-1:0] no_data_total;
        logic             pacing_warn;
        logic             stale_warn;
        logic             no_data_warn;
    } health_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

@@ sv/producer_health_monitor.sv @@
// Top level: polled producer health checks with saturating warning counters.
//
// Usage:
//   Each transaction on the s_ channel is one poll: current time, heartbeat time,
//   block timestamp and the write and read index snapshots. Each poll yields exactly
//   one transaction on the m_ channel: three warning flags (no-data, stale heartbeat,
//   pacing drift) and the three saturating 32-bit totals after that poll.
//   Each accepted poll passes through one input register, then the checks and
//   state update in a single pass into the result register that drives m_tvalid.
//   Throughput is one poll per cycle while the receiver takes each result; the
//   limit is the 64-bit subtract and compare path between the input and result registers.
//   The APB port sets thresholds, rate-limit intervals and the block period;
//   write it only while no poll is in flight.
//   Reset restores the default register values, clears counters, the no-data latch
//   and all rate-limit and timestamp history.
//   When the receiver stalls, the result is held and one more poll is taken into the
//   input register; s_tready then drops until the result is taken.
`timescale 1ns / 1ps

module producer_health_monitor
    import phm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    // now_ms, heartbeat_ms, block_pts_ns, write_index, read_index (64 bits each)
    input  logic [IN_W-1:0]   s_tdata,

    output logic              m_tvalid,
    input  logic              m_tready,
    // no_data_warn, stale_warn, pacing_warn, no_data_total, stale_total,
    // pacing_total (32 each), 5 bits zero fill
    output logic [OUT_W-1:0]  m_tdata,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    logic [CFG_W-1:0]    stale_threshold_reg;
    logic [CFG_W-1:0]    stale_interval_reg;
    logic [CFG_W-1:0]    pacing_interval_reg;
    logic [PERIOD_W-1:0] block_period_reg;

    poll_t   in_data_reg;
    logic    in_valid_reg;
    health_t out_data_reg;
    logic    out_valid_reg;

    logic              no_data_latched_reg;
    logic [CNT_W-1:0]  no_data_count_reg;
    logic [CNT_W-1:0]  stale_count_reg;
    logic [CNT_W-1:0]  pacing_count_reg;
    logic              stale_time_valid_reg;
    logic [TIME_W-1:0] last_stale_time_reg;
    logic              pacing_time_valid_reg;
    logic [TIME_W-1:0] last_pacing_time_reg;
    logic              prev_stamp_valid_reg;
    logic [TIME_W-1:0] prev_stamp_reg;

    logic              cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic              advance;

    logic              nd_hit;
    logic [TIME_W-1:0] hb_age;
    logic              stale_cond;
    logic [TIME_W-1:0] stale_elapsed;
    logic              stale_open;
    logic              stale_hit;
    logic [TIME_W-1:0] pts_up;
    logic [TIME_W-1:0] pts_dn;
    logic [TIME_W-1:0] pts_delta;
    logic              pts_rise;
    logic              pts_moved;
    logic [TIME_W-1:0] pacing_elapsed;
    logic              pacing_open;
    logic              pacing_hit;
    health_t           res_next;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_STALE_THRESHOLD: prdata = stale_threshold_reg;
            REG_STALE_INTERVAL:  prdata = stale_interval_reg;
            REG_PACING_INTERVAL: prdata = pacing_interval_reg;
            REG_BLOCK_PERIOD:    prdata = {{(CFG_W-PERIOD_W){1'b0}}, block_period_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_threshold_reg <= STALE_THRESHOLD_RST;
            stale_interval_reg  <= STALE_INTERVAL_RST;
            pacing_interval_reg <= PACING_INTERVAL_RST;
            block_period_reg    <= BLOCK_PERIOD_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_STALE_THRESHOLD: stale_threshold_reg <= pwdata;
                REG_STALE_INTERVAL:  stale_interval_reg  <= pwdata;
                REG_PACING_INTERVAL: pacing_interval_reg <= pwdata;
                REG_BLOCK_PERIOD:    block_period_reg    <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-$bits(health_t)){1'b0}}, out_data_reg};

    // Checks
    assign nd_hit = !no_data_latched_reg && (in_data_reg.write_index == '0)
                    && (in_data_reg.read_index == '0);

    assign hb_age     = in_data_reg.now_ms - in_data_reg.heartbeat_ms;
    assign stale_cond = (in_data_reg.now_ms >= in_data_reg.heartbeat_ms)
                        && (hb_age > {{(TIME_W-CFG_W){1'b0}}, stale_threshold_reg});
    assign stale_elapsed = in_data_reg.now_ms - last_stale_time_reg;
    assign stale_open = !stale_time_valid_reg
                        || (stale_elapsed >= {{(TIME_W-CFG_W){1'b0}}, stale_interval_reg});
    assign stale_hit  = stale_cond && stale_open;

    assign pts_up    = in_data_reg.block_pts_ns - prev_stamp_reg;
    assign pts_dn    = prev_stamp_reg - in_data_reg.block_pts_ns;
    assign pts_rise  = in_data_reg.block_pts_ns > prev_stamp_reg;
    assign pts_delta = pts_rise ? pts_up : pts_dn;
    assign pts_moved = prev_stamp_valid_reg && (in_data_reg.block_pts_ns != prev_stamp_reg);
    assign pacing_elapsed = in_data_reg.now_ms - last_pacing_time_reg;
    assign pacing_open = !pacing_time_valid_reg
                         || (pacing_elapsed >= {{(TIME_W-CFG_W){1'b0}}, pacing_interval_reg});
    assign pacing_hit = pts_moved && pacing_open
                        && (pts_delta > {{(TIME_W-PERIOD_W){1'b0}}, block_period_reg});

    always_comb begin
        res_next.no_data_warn  = nd_hit;
        res_next.stale_warn    = stale_hit;
        res_next.pacing_warn   = pacing_hit;
        res_next.no_data_total = nd_hit ? sat_inc(no_data_count_reg) : no_data_count_reg;
        res_next.stale_total   = stale_hit ? sat_inc(stale_count_reg) : stale_count_reg;
        res_next.pacing_total  = pacing_hit ? sat_inc(pacing_count_reg) : pacing_count_reg;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= poll_t'(s_tdata);
        end
        if (advance) begin
            out_data_reg <= res_next;
        end
    end

    // Control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            no_data_latched_reg   <= 1'b0;
            no_data_count_reg     <= '0;
            stale_count_reg       <= '0;
            pacing_count_reg      <= '0;
            stale_time_valid_reg  <= 1'b0;
            last_stale_time_reg   <= '0;
            pacing_time_valid_reg <= 1'b0;
            last_pacing_time_reg  <= '0;
            prev_stamp_valid_reg  <= 1'b0;
            prev_stamp_reg        <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                no_data_count_reg <= res_next.no_data_total;
                stale_count_reg   <= res_next.stale_total;
                pacing_count_reg  <= res_next.pacing_total;
                if (nd_hit) begin
                    no_data_latched_reg <= 1'b1;
                end
                if (stale_hit) begin
                    stale_time_valid_reg <= 1'b1;
                    last_stale_time_reg  <= in_data_reg.now_ms;
                end
                if (pacing_hit) begin
                    pacing_time_valid_reg <= 1'b1;
                    last_pacing_time_reg  <= in_data_reg.now_ms;
                end
                prev_stamp_valid_reg <= 1'b1;
                prev_stamp_reg       <= in_data_reg.block_pts_ns;
            end
        end
    end

    // Assertions
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while pipeline had room");

    a_no_data_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && nd_hit) |-> !no_data_latched_reg)
        else $error("no-data warning raised after latch");

    a_stale_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (stale_count_reg >= $past(stale_count_reg)))
        else $error("stale counter decreased");

    a_pacing_needs_history: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && pacing_hit) |-> prev_stamp_valid_reg)
        else $error("pacing warning without previous timestamp");

    a_stale_records_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stale_hit) |=> (stale_time_valid_reg
                                    && last_stale_time_reg == $past(in_data_reg.now_ms)))
        else $error("stale warning did not record its time");

endmodule

@@ dv/phm_checker.sv @@
// Checker for the producer health monitor: tracks configuration, predicts each result, compares.
`timescale 1ns / 1ps

module phm_checker
    import phm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,

    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    input  logic              pready,

    output int                fail_count,
    output int                pending
);

    logic [CFG_W-1:0]    stale_limit;
    logic [CFG_W-1:0]    stale_gap;
    logic [CFG_W-1:0]    pacing_gap;
    logic [PERIOD_W-1:0] period;

    logic                nd_latched;
    logic [CNT_W-1:0]    nd_cnt;
    logic [CNT_W-1:0]    stale_cnt;
    logic [CNT_W-1:0]    pacing_cnt;
    logic                stale_seen;
    logic [TIME_W-1:0]   stale_last;
    logic                pacing_seen;
    logic [TIME_W-1:0]   pacing_last;
    logic                stamp_seen;
    logic [TIME_W-1:0]   stamp;

    health_t             expected_health[$];

    task automatic assess_poll(input poll_t p, output health_t h);
        logic [TIME_W-1:0] delta;
        h = '0;
        if (!nd_latched && p.write_index == '0 && p.read_index == '0) begin
            if (nd_cnt != CNT_MAX) nd_cnt++;
            nd_latched = 1'b1;
            h.no_data_warn = 1'b1;
        end
        if (p.now_ms >= p.heartbeat_ms &&
            (p.now_ms - p.heartbeat_ms) > TIME_W'(stale_limit)) begin
            if (!stale_seen || (p.now_ms - stale_last) >= TIME_W'(stale_gap)) begin
                if (stale_cnt != CNT_MAX) stale_cnt++;
                stale_last = p.now_ms;
                stale_seen = 1'b1;
                h.stale_warn = 1'b1;
            end
        end
        if (!stamp_seen) begin
            stamp = p.block_pts_ns;
            stamp_seen = 1'b1;
        end else if (p.block_pts_ns != stamp) begin
            delta = (p.block_pts_ns > stamp) ? p.block_pts_ns - stamp
                                             : stamp - p.block_pts_ns;
            stamp = p.block_pts_ns;
            if (delta > TIME_W'(period)) begin
                if (!pacing_seen || (p.now_ms - pacing_last) >= TIME_W'(pacing_gap)) begin
                    if (pacing_cnt != CNT_MAX) pacing_cnt++;
                    pacing_last = p.now_ms;
                    pacing_seen = 1'b1;
                    h.pacing_warn = 1'b1;
                end
            end
        end
        h.no_data_total = nd_cnt;
        h.stale_total   = stale_cnt;
        h.pacing_total  = pacing_cnt;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        health_t got;
        health_t want;
        if (!aresetn) begin
            stale_limit = STALE_THRESHOLD_RST;
            stale_gap   = STALE_INTERVAL_RST;
            pacing_gap  = PACING_INTERVAL_RST;
            period      = BLOCK_PERIOD_RST;
            nd_latched  = 1'b0;
            nd_cnt      = '0;
            stale_cnt   = '0;
            pacing_cnt  = '0;
            stale_seen  = 1'b0;
            stale_last  = '0;
            pacing_seen = 1'b0;
            pacing_last = '0;
            stamp_seen  = 1'b0;
            stamp       = '0;
            expected_health.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = health_t'(m_tdata[$bits(health_t)-1:0]);
                if (expected_health.size() == 0) begin
                    $error("result transaction with no poll outstanding");
                    fail_count++;
                end else begin
                    want = expected_health.pop_front();
                    check_field("no_data_warn", CNT_W'(want.no_data_warn),
                                CNT_W'(got.no_data_warn));
                    check_field("stale_warn", CNT_W'(want.stale_warn),
                                CNT_W'(got.stale_warn));
                    check_field("pacing_warn", CNT_W'(want.pacing_warn),
                                CNT_W'(got.pacing_warn));
                    check_field("no_data_total", want.no_data_total, got.no_data_total);
                    check_field("stale_total", want.stale_total, got.stale_total);
                    check_field("pacing_total", want.pacing_total, got.pacing_total);
                end
            end
            if (s_tvalid && s_tready) begin
                assess_poll(poll_t'(s_tdata), want);
                expected_health.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_STALE_THRESHOLD: stale_limit = pwdata;
                    REG_STALE_INTERVAL:  stale_gap   = pwdata;
                    REG_PACING_INTERVAL: pacing_gap  = pwdata;
                    REG_BLOCK_PERIOD:    period      = pwdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_health.size();
    end

endmodule

@@ dv/producer_health_monitor_tb.sv @@
// Testbench top for the producer health monitor: clock, reset, poll stimulus and verdict.
`timescale 1ns / 1ps

module producer_health_monitor_tb;
    import phm_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_POLLS  = 75;
    localparam int CYCLE_LIMIT  = 400000;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    // now_ms, heartbeat_ms, block_pts_ns, write_index, read_index (64 bits each)
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // no_data_warn, stale_warn, pacing_warn, no_data_total, stale_total,
    // pacing_total (32 each), 5 bits zero fill
    logic [OUT_W-1:0]  m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                cycle_count;
    int                idle_pct;
    int                stall_pct;

    logic [TIME_W-1:0]   time_now;
    logic [TIME_W-1:0]   stamp_now;
    logic [CFG_W-1:0]    cur_thr;
    logic [PERIOD_W-1:0] cur_period;

    producer_health_monitor dut (.*);
    phm_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) m_tready = ($urandom_range(99) >= stall_pct);

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] thr, s_ivl, p_ivl,
                                input logic [PERIOD_W-1:0] period);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (2) @(posedge aclk);
        reg_write(REG_STALE_THRESHOLD, thr);
        reg_write(REG_STALE_INTERVAL, s_ivl);
        reg_write(REG_PACING_INTERVAL, p_ivl);
        reg_write(REG_BLOCK_PERIOD, CFG_W'(period));
        cur_thr    = thr;
        cur_period = period;
    endtask

    task automatic send_poll(input poll_t p);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = p;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(input logic [TIME_W-1:0] now, hb, pts, wi, ri);
        poll_t p;
        p.now_ms       = now;
        p.heartbeat_ms = hb;
        p.block_pts_ns = pts;
        p.write_index  = wi;
        p.read_index   = ri;
        send_poll(p);
    endtask

    task automatic make_poll(output poll_t p);
        int                pick;
        logic [TIME_W-1:0] age;
        pick = $urandom_range(99);
        if (pick < 45)      time_now += $urandom_range(0, 200);
        else if (pick < 75) time_now += $urandom_range(0, 40000);
        else if (pick < 85) time_now += $urandom;
        else if (pick < 93) time_now -= $urandom_range(1, 5000);
        else                time_now = rand64();

        pick = $urandom_range(99);
        if (pick < 20)      age = TIME_W'(cur_thr);
        else if (pick < 40) age = TIME_W'(cur_thr) + 1;
        else if (pick < 60) age = TIME_W'($urandom_range(cur_thr));
        else if (pick < 80) age = TIME_W'(cur_thr) + $urandom_range(1, 1000);
        else if (pick < 92) age = -TIME_W'($urandom_range(1, 1000));
        else                age = rand64();
        p.now_ms       = time_now;
        p.heartbeat_ms = time_now - age;

        pick = $urandom_range(99);
        if (pick < 20)      ;
        else if (pick < 40) stamp_now += TIME_W'(cur_period);
        else if (pick < 55) stamp_now += TIME_W'(cur_period) + 1;
        else if (pick < 65) stamp_now -= TIME_W'(cur_period) + 1;
        else if (pick < 85) stamp_now += $urandom_range(cur_period);
        else if (pick < 92) stamp_now -= $urandom_range(cur_period);
        else                stamp_now = rand64();
        p.block_pts_ns = stamp_now;

        pick = $urandom_range(99);
        if (pick < 4) begin
            p.write_index = '0;
            p.read_index  = '0;
        end else if (pick < 8) begin
            p.write_index = '0;
            p.read_index  = rand64();
        end else if (pick < 12) begin
            p.write_index = rand64();
            p.read_index  = '0;
        end else if (pick < 20) begin
            p.write_index = $urandom_range(0, 3);
            p.read_index  = $urandom_range(0, 3);
        end else begin
            p.write_index = rand64();
            p.read_index  = rand64();
        end
    endtask

    initial begin
        poll_t p;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        time_now   = 64'd100000;
        stamp_now  = 64'd0;
        cur_thr    = STALE_THRESHOLD_RST;
        cur_period = BLOCK_PERIOD_RST;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // default registers: latch, thresholds, rate limits and clock steps
        send_fields(1000, 1000, 0, 0, 0);
        send_fields(1000, 1000, 0, 0, 0);
        send_fields(1000, 899, 0, 5, 7);
        send_fields(1001, 0, 0, rand64(), rand64());
        send_fields(31000, 30900, 0, rand64(), rand64());
        send_fields(31000, 0, 0, rand64(), rand64());
        send_fields(40000, 50000, 2666666, rand64(), rand64());
        send_fields(40000, 50000, 2666666, rand64(), rand64());
        send_fields(40000, 50000, 5333333, rand64(), rand64());
        send_fields(40001, 50000, 0, rand64(), rand64());
        send_fields(45001, 50000, '1, rand64(), rand64());
        send_fields(500, 0, 0, rand64(), rand64());
        send_fields('1, 0, '1, '1, '1);
        send_fields(0, 0, 0, 0, 1);

        // zero intervals: every qualifying poll warns
        apply_config('0, '0, '0, '0);
        send_fields(5, 4, 1, rand64(), rand64());
        send_fields(5, 4, 2, rand64(), rand64());
        send_fields(5, 5, 2, rand64(), rand64());

        // widest settings
        apply_config('1, '1, '1, 30'd1000000000);
        send_fields(64'h1_0000_000A, 64'hA, 64'd1000000003, rand64(), rand64());
        send_fields(64'h1_0000_0010, 64'h10, 64'd2000000003, rand64(), rand64());
        send_fields('1, 64'hFFFF_FFFE_FFFF_FFFF, 64'd3, rand64(), rand64());

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0, 7: apply_config(STALE_THRESHOLD_RST, STALE_INTERVAL_RST,
                                   PACING_INTERVAL_RST, BLOCK_PERIOD_RST);
                1, 6: apply_config($urandom_range(0, 20), $urandom_range(0, 20),
                                   $urandom_range(0, 20), $urandom_range(0, 20));
                2:    apply_config('0, '0, '0, '0);
                3:    apply_config(1, 1, 1, 1);
                4:    apply_config('1, '1, '1, 30'd1000000000);
                default: apply_config($urandom, $urandom, $urandom,
                                      $urandom_range(0, 1000000000));
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (int i = 0; i < PHASE_POLLS; i++) begin
                make_poll(p);
                send_poll(p);
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
